### hdl/hac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hac_pkg: shared constants for the heavy-atom contact test
// Opcodes, configuration register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package hac_pkg;

  localparam int DEF_MAX_RESIDUES    = 256;
  localparam int DEF_MAX_HEAVY_ATOMS = 32;
  localparam int DEF_COORD_BITS      = 20;

  localparam int RES_FIELD_W = 8;
  localparam int OP_W        = 2;
  localparam int CUTOFF_W    = 42;
  localparam int LINKS_W     = 11;
  localparam int SEP_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 42;
  localparam int OUT_W       = 16;

  // Magnitudes of 2^21 or more square beyond any cutoff.
  localparam int SQ_W = 21;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINKS_NEEDED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEQ_SEP  = 2'd2;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET       = 42'd1327104;
  localparam logic [LINKS_W-1:0]  LINKS_NEEDED_RESET = 11'd2;
  localparam logic [SEP_W-1:0]    MIN_SEP_RESET      = 8'd2;

endpackage

### hdl/heavy_atom_contact_test.sv
`timescale 1ns / 1ps
// A query walks the atom pairs of residues a and b one pair at a time through a single
// shared squaring multiplier. The block takes one item at a time.
// Reset is synchronous: atom counts read as zero and registers take defaults.
// ----------------------------------------------------------------------------
// heavy_atom_contact_test
// Per-residue heavy-atom lists with an iterative pairwise contact count.
// ----------------------------------------------------------------------------
module heavy_atom_contact_test #(
  parameter int MAX_RESIDUES    = hac_pkg::DEF_MAX_RESIDUES,
  parameter int MAX_HEAVY_ATOMS = hac_pkg::DEF_MAX_HEAVY_ATOMS,
  parameter int COORD_BITS      = hac_pkg::DEF_COORD_BITS,
  localparam int IN_W = ((2 * hac_pkg::RES_FIELD_W + hac_pkg::OP_W + 3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // opcode, residue_a, residue_b, pos_x, pos_y, pos_z (from bit 0 up)
  input  logic [IN_W-1:0]                   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // in_contact, links_found, status (from bit 0 up)
  output logic [hac_pkg::OUT_W-1:0]         m_axis_tdata,
  input  logic                              cfg_wr_en,
  input  logic [hac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hac_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hac_pkg::*;

  localparam int RW     = RES_FIELD_W;
  localparam int RES_W  = (MAX_RESIDUES > 1) ? $clog2(MAX_RESIDUES) : 1;
  localparam int AI_W   = (MAX_HEAVY_ATOMS > 1) ? $clog2(MAX_HEAVY_ATOMS) : 1;
  localparam int CNT_W  = $clog2(MAX_HEAVY_ATOMS + 1);
  localparam int ADDR_W = RES_W + AI_W;
  localparam int DEPTH  = MAX_RESIDUES << AI_W;
  localparam int CB     = COORD_BITS;
  localparam int POS_W  = 3 * CB;
  localparam int MAG_W  = CB + 1;
  localparam int PROD_W = 2 * SQ_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int LK_RAW = $clog2(MAX_HEAVY_ATOMS * MAX_HEAVY_ATOMS + 1);
  localparam int LK_W   = (LK_RAW > LINKS_W) ? LK_RAW : LINKS_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_APP  = 4'd2;
  localparam logic [3:0] S_QCA  = 4'd3;
  localparam logic [3:0] S_QCB  = 4'd4;
  localparam logic [3:0] S_LA   = 4'd5;
  localparam logic [3:0] S_LB   = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]          state;
  logic [CUTOFF_W-1:0] cutoff_sq;
  logic [LINKS_W-1:0]  links_needed;
  logic [SEP_W-1:0]    min_seq_sep;

  logic [OP_W-1:0]     op;
  logic [RW-1:0]       res_a;
  logic [RW-1:0]       res_b;
  logic [POS_W-1:0]    pos_in;

  logic [CNT_W-1:0]    na, nb;
  logic [AI_W-1:0]     ia, ib;
  logic signed [CB-1:0] ax, ay, az;
  logic [MAG_W-1:0]    mag [3];
  logic                far;
  logic [1:0]          k;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum;
  logic [LK_W-1:0]     links;
  logic                contact;
  logic                status;

  logic                out_valid;
  logic [OUT_W-1:0]    out_data;

  // Atom coordinate store and per-residue counts.
  logic [POS_W-1:0]    pos_mem [DEPTH];
  logic [POS_W-1:0]    pos_rdata;
  logic                pos_we;
  logic [ADDR_W-1:0]   pos_waddr, pos_raddr;
  logic [CNT_W-1:0]    cnt_mem [MAX_RESIDUES];
  logic [MAX_RESIDUES-1:0] cnt_valid;
  logic [CNT_W-1:0]    cnt_rd;
  logic [RES_W-1:0]    cnt_raddr;

  logic                a_ok, b_ok;
  logic [RW-1:0]       sep;
  logic signed [CB-1:0] bx, by, bz;
  logic signed [MAG_W-1:0] dx, dy, dz;
  logic [SQ_W-1:0]     sq_in;
  logic                close;
  logic [LK_W-1:0]     links_inc;

  assign a_ok = 32'(res_a) < MAX_RESIDUES;
  assign b_ok = 32'(res_b) < MAX_RESIDUES;
  assign sep  = (res_a > res_b) ? res_a - res_b : res_b - res_a;

  assign bx = pos_rdata[CB-1:0];
  assign by = pos_rdata[2*CB-1:CB];
  assign bz = pos_rdata[3*CB-1:2*CB];
  assign dx = MAG_W'(ax) - MAG_W'(bx);
  assign dy = MAG_W'(ay) - MAG_W'(by);
  assign dz = MAG_W'(az) - MAG_W'(bz);

  always_comb begin
    unique case (k)
      2'd0:    sq_in = SQ_W'(mag[0]);
      2'd1:    sq_in = SQ_W'(mag[1]);
      default: sq_in = SQ_W'(mag[2]);
    endcase
  end

  assign close     = !far && (sum < SUM_W'(cutoff_sq));
  assign links_inc = links + LK_W'(1);

  // Memory addressing per state.
  always_comb begin
    pos_we    = 1'b0;
    pos_waddr = {RES_W'(res_a), AI_W'(cnt_rd)};
    cnt_raddr = RES_W'(res_a);
    pos_raddr = {RES_W'(res_a), ia};
    unique case (state)
      S_APP:   pos_we = (cnt_rd < CNT_W'(MAX_HEAVY_ATOMS));
      S_QCA:   cnt_raddr = RES_W'(res_b);
      S_QCB:   pos_raddr = {RES_W'(res_a), AI_W'(0)};
      S_LA:    pos_raddr = {RES_W'(res_b), AI_W'(0)};
      S_CMP: begin
        if ((CNT_W'(ib) + CNT_W'(1)) < nb) begin
          pos_raddr = {RES_W'(res_b), ib + AI_W'(1)};
        end else begin
          pos_raddr = {RES_W'(res_a), ia + AI_W'(1)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_in;
    end
    pos_rdata <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_APP && pos_we) begin
      cnt_mem[RES_W'(res_a)] <= cnt_rd + CNT_W'(1);
    end
    cnt_rd <= cnt_valid[cnt_raddr] ? cnt_mem[cnt_raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
    end else if (state == S_APP && pos_we) begin
      cnt_valid[RES_W'(res_a)] <= 1'b1;
    end else if (state == S_RDA && op == OP_CLEAR && a_ok) begin
      cnt_valid[RES_W'(res_a)] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_sq    <= CUTOFF_RESET;
      links_needed <= LINKS_NEEDED_RESET;
      min_seq_sep  <= MIN_SEP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CUTOFF_SQ:    cutoff_sq    <= cfg_data[CUTOFF_W-1:0];
        REG_LINKS_NEEDED: links_needed <= cfg_data[LINKS_W-1:0];
        REG_MIN_SEQ_SEP:  min_seq_sep  <= cfg_data[SEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In S_OUT the output register is always left holding a result.
      if (m_axis_tready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op      <= s_axis_tdata[OP_W-1:0];
            res_a   <= s_axis_tdata[OP_W+RW-1:OP_W];
            res_b   <= s_axis_tdata[OP_W+2*RW-1:OP_W+RW];
            pos_in  <= s_axis_tdata[OP_W+2*RW+POS_W-1:OP_W+2*RW];
            links   <= '0;
            contact <= 1'b0;
            status  <= 1'b0;
            state   <= S_RDA;
          end
        end
        S_RDA: begin
          if (op == OP_APPEND) begin
            if (a_ok) begin
              state <= S_APP;
            end else begin
              status <= 1'b1;
              state  <= S_OUT;
            end
          end else if (op == OP_QUERY && a_ok && b_ok && sep >= min_seq_sep) begin
            state <= S_QCA;
          end else begin
            state <= S_OUT;
          end
        end
        S_APP: begin
          status <= !pos_we;
          state  <= S_OUT;
        end
        S_QCA: begin
          na    <= cnt_rd;
          state <= S_QCB;
        end
        S_QCB: begin
          nb <= cnt_rd;
          ia <= '0;
          ib <= '0;
          if (na == '0 || cnt_rd == '0) begin
            state <= S_OUT;
          end else begin
            state <= S_LA;
          end
        end
        S_LA: begin
          ax    <= bx;
          ay    <= by;
          az    <= bz;
          state <= S_LB;
        end
        S_LB: begin
          mag[0] <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
          mag[1] <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
          mag[2] <= dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
          far    <= 1'b0;
          sum    <= '0;
          k      <= 2'd0;
          state  <= S_SQ;
        end
        S_SQ: begin
          // The shared multiplier squares one axis per cycle; the previous
          // square is added in the same cycle.
          if (k == 2'd0) begin
            far <= ((mag[0] >> SQ_W) != '0) || ((mag[1] >> SQ_W) != '0) ||
                   ((mag[2] >> SQ_W) != '0);
          end else begin
            sum <= sum + SUM_W'(prod);
          end
          prod <= PROD_W'(sq_in * sq_in);
          k    <= k + 2'd1;
          if (k == 2'd3) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (close) begin
            links <= links_inc;
          end
          if (close && links_inc >= LK_W'(links_needed)) begin
            contact <= 1'b1;
            state   <= S_OUT;
          end else if ((CNT_W'(ib) + CNT_W'(1)) < nb) begin
            ib    <= ib + AI_W'(1);
            state <= S_LB;
          end else if ((CNT_W'(ia) + CNT_W'(1)) < na) begin
            ia    <= ia + AI_W'(1);
            ib    <= '0;
            state <= S_LA;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_data  <= OUT_W'({status, links[LINKS_W-1:0], contact});
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  a_contact_has_links: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[LINKS_W:1] != '0)
    else $error("contact reported with no close pairs");

  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[LINKS_W+1] |-> m_axis_tdata[LINKS_W:0] == '0)
    else $error("dropped append carries query fields");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> (CNT_W'(ia) < na) && (CNT_W'(ib) < nb))
    else $error("pair walk outside the atom lists");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for heavy_atom_contact_test
// Builds per-residue heavy-atom lists, then checks every result (query, append,
// clear and no operation) against a cycle-free software copy of the contact count.
// The test runs under several register settings and random idling.
// ----------------------------------------------------------------------------
module testbench;
  import hac_pkg::*;

  localparam int IN_W        = 80;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic               contact;
    logic [LINKS_W-1:0] links;
    logic               status;
  } contact_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // opcode, residue_a, residue_b, pos_x, pos_y, pos_z (from bit 0 up)
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // in_contact, links_found, status (from bit 0 up)
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  heavy_atom_contact_test dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Software copy of the block state and registers.
  int                  atom_mem [256][32][3];
  int                  atom_count [256];
  logic [CUTOFF_W-1:0] cutoff_q;
  logic [LINKS_W-1:0]  links_needed_q;
  logic [SEP_W-1:0]    min_sep_q;

  contact_result_t expected_q[$];
  int  mismatches = 0;
  int  cycles = 0;
  int  hold_cycles = 0;
  bit  no_idle = 0;
  int  pool_base = 0;

  function automatic contact_result_t predict_item(logic [OP_W-1:0] op, int ra, int rb,
                                                   int x, int y, int z);
    contact_result_t r;
    int  sep;
    int  cnt;
    bit  done;
    longint dx, dy, dz, sum;
    r = '0;
    cnt = 0;
    done = 0;
    case (op)
      OP_APPEND: begin
        if (atom_count[ra] >= 32) begin
          r.status = 1'b1;
        end else begin
          atom_mem[ra][atom_count[ra]][0] = x;
          atom_mem[ra][atom_count[ra]][1] = y;
          atom_mem[ra][atom_count[ra]][2] = z;
          atom_count[ra]++;
        end
      end
      OP_CLEAR: atom_count[ra] = 0;
      OP_QUERY: begin
        sep = (ra > rb) ? ra - rb : rb - ra;
        if (sep >= int'(min_sep_q)) begin
          for (int a = 0; a < atom_count[ra] && !done; a++) begin
            for (int b = 0; b < atom_count[rb] && !done; b++) begin
              dx = longint'(atom_mem[ra][a][0]) - atom_mem[rb][b][0];
              dy = longint'(atom_mem[ra][a][1]) - atom_mem[rb][b][1];
              dz = longint'(atom_mem[ra][a][2]) - atom_mem[rb][b][2];
              sum = dx * dx + dy * dy + dz * dz;
              if (sum < longint'({22'd0, cutoff_q})) begin
                cnt++;
                // A zero minimum behaves as one: the test follows the increment.
                if (cnt >= int'(links_needed_q)) begin
                  r.contact = 1'b1;
                  done = 1;
                end
              end
            end
          end
        end
        r.links = cnt[LINKS_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, int ra, int rb,
                           logic signed [19:0] x, logic signed [19:0] y,
                           logic signed [19:0] z);
    int gap;
    s_axis_tdata  <= {2'b00, z, y, x, rb[7:0], ra[7:0], op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_q.push_back(predict_item(op, ra[7:0], rb[7:0], x, y, z));
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_settings(logic [CUTOFF_W-1:0] cut, logic [LINKS_W-1:0] links,
                                logic [SEP_W-1:0] sep);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CUTOFF_SQ;
    cfg_data  <= cut;
    @(posedge clk);
    cutoff_q  = cut;
    cfg_index <= REG_LINKS_NEEDED;
    cfg_data  <= CFG_DATA_W'(links);
    @(posedge clk);
    links_needed_q = links;
    cfg_index <= REG_MIN_SEQ_SEP;
    cfg_data  <= CFG_DATA_W'(sep);
    @(posedge clk);
    min_sep_q = sep;
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly clustered coordinates so that close pairs occur; sometimes any value.
  function automatic logic signed [19:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return 20'($urandom);
    return 20'(4096 + $urandom_range(0, 1400));
  endfunction

  task automatic send_random(int n);
    int r, ra, rb;
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(0, 99);
      ra = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                       : pool_base + $urandom_range(0, 5);
      rb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                       : pool_base + $urandom_range(0, 5);
      if (r < 45)      send_item(OP_APPEND, ra, rb, rand_coord(), rand_coord(), rand_coord());
      else if (r < 55) send_item(OP_CLEAR, ra, rb, rand_coord(), rand_coord(), rand_coord());
      else if (r < 95) send_item(OP_QUERY, ra, rb, rand_coord(), rand_coord(), rand_coord());
      else             send_item(OP_NOP, ra, rb, 20'($urandom), 20'($urandom), 20'($urandom));
    end
  endtask

  task automatic test_directed();
    send_item(OP_NOP, 255, 255, -20'sd1, -20'sd1, -20'sd1);
    send_item(OP_APPEND, 0, 0, -20'sd524288, 20'sd524287, 20'sd0);
    send_item(OP_APPEND, 0, 0, 20'sd100, 20'sd100, 20'sd100);
    send_item(OP_APPEND, 255, 0, 20'sd524287, -20'sd524288, -20'sd1);
    send_item(OP_APPEND, 255, 0, 20'sd200, 20'sd100, 20'sd100);
    send_item(OP_APPEND, 255, 0, 20'sd150, 20'sd150, 20'sd100);
    send_item(OP_QUERY, 0, 255, 0, 0, 0);
    send_item(OP_QUERY, 255, 0, 0, 0, 0);
    send_item(OP_QUERY, 0, 1, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 0, 0);
    send_item(OP_QUERY, 7, 200, 0, 0, 0);
    send_item(OP_CLEAR, 255, 0, 0, 0, 0);
    send_item(OP_QUERY, 0, 255, 0, 0, 0);
    send_item(OP_CLEAR, 77, 0, 0, 0, 0);
  endtask

  // Fills two lists to capacity, overflows one and walks all pairs.
  task automatic test_full_lists();
    for (int i = 0; i < 32; i++) begin
      send_item(OP_APPEND, 20, 0, 20'(i * 3000), 0, 0);
      send_item(OP_APPEND, 23, 0, 20'(i * 3000 + 200), 300, 0);
    end
    send_item(OP_APPEND, 20, 0, 0, 0, 0);
    send_item(OP_QUERY, 20, 23, 0, 0, 0);
    write_settings(42'h3FF_FFFF_FFFF, 11'd1024, 8'd0);
    send_item(OP_QUERY, 23, 20, 0, 0, 0);
    send_item(OP_QUERY, 20, 20, 0, 0, 0);
    send_item(OP_CLEAR, 20, 0, 0, 0, 0);
    send_item(OP_CLEAR, 23, 0, 0, 0, 0);
  endtask

  task automatic test_random_phases();
    pool_base = $urandom_range(0, 250);
    write_settings(CUTOFF_RESET, LINKS_NEEDED_RESET, MIN_SEP_RESET);
    send_random(120);
    no_idle = 1;
    write_settings(42'h3FF_FFFF_FFFF, 11'd1024, 8'd0);
    send_random(80);
    no_idle = 0;
    write_settings('0, 11'd0, 8'd255);
    send_random(30);
    send_item(OP_QUERY, 0, 255, 0, 0, 0);
    write_settings(CUTOFF_W'($urandom_range(0, 4000000)), 11'd0, 8'd1);
    send_random(100);
    pool_base = $urandom_range(0, 250);
    write_settings(CUTOFF_W'($urandom_range(200000, 3000000)),
                   LINKS_W'($urandom_range(1, 4)), SEP_W'($urandom_range(0, 3)));
    send_random(130);
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    no_idle = 1;
    hold_cycles = 400;
    send_random(35);
    no_idle = 0;
  endtask

  initial begin
    for (int i = 0; i < 256; i++) atom_count[i] = 0;
    cutoff_q       = CUTOFF_RESET;
    links_needed_q = LINKS_NEEDED_RESET;
    min_sep_q      = MIN_SEP_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_lists();
    test_random_phases();
    test_backpressure();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    contact_result_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[0], m_axis_tdata[11:1], m_axis_tdata[12]};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected contact %0d links %0d status %0d, got %0d %0d %0d",
                     want.contact, want.links, want.status,
                     got.contact, got.links, got.status);
        end
      end
    end
  end

endmodule
